// ===== rtl/core/fclb_pkg.sv =====
// Fault code LED blinker package: phase codes, register indexes, shared types,
// the fault table and the helper functions for mask mapping and code search.
// No dependencies.
`default_nettype none

package fclb_pkg;

    localparam int TABLE_ENTRIES  = 8;
    localparam int TIME_BITS      = 12;
    localparam int CODE_BITS      = 3;
    localparam int NUM_CODES      = 7;
    localparam int MASK_BITS      = 16;
    localparam int POS_BITS       = 4;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int PHASE_BITS     = 4;

    // Request commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CODE_BIT_POSITIONS = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ON_TIME            = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PAUSE_TIME         = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RED_OFF_TIME       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BLUE_OFF_TIME      = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROUND_GAP_TIME     = 3'd5;

    // Reset values of the timing registers, in milliseconds
    localparam logic [TIME_BITS-1:0] ON_TIME_RST        = TIME_BITS'(200);
    localparam logic [TIME_BITS-1:0] PAUSE_TIME_RST     = TIME_BITS'(200);
    localparam logic [TIME_BITS-1:0] RED_OFF_TIME_RST   = TIME_BITS'(350);
    localparam logic [TIME_BITS-1:0] BLUE_OFF_TIME_RST  = TIME_BITS'(500);
    localparam logic [TIME_BITS-1:0] ROUND_GAP_TIME_RST = TIME_BITS'(750);

    // Pattern phases
    localparam logic [PHASE_BITS-1:0] PH_IDLE   = 4'd0;
    localparam logic [PHASE_BITS-1:0] PH_G_ON   = 4'd1;
    localparam logic [PHASE_BITS-1:0] PH_G_OFF  = 4'd2;
    localparam logic [PHASE_BITS-1:0] PH_PAUSE1 = 4'd3;
    localparam logic [PHASE_BITS-1:0] PH_R_ON   = 4'd4;
    localparam logic [PHASE_BITS-1:0] PH_R_OFF  = 4'd5;
    localparam logic [PHASE_BITS-1:0] PH_PAUSE2 = 4'd6;
    localparam logic [PHASE_BITS-1:0] PH_B_ON   = 4'd7;
    localparam logic [PHASE_BITS-1:0] PH_B_OFF  = 4'd8;
    localparam logic [PHASE_BITS-1:0] PH_PAUSE3 = 4'd9;
    localparam logic [PHASE_BITS-1:0] PH_GAP    = 4'd10;

    // Fixed fault code carried by each table entry
    localparam logic [CODE_BITS-1:0] ENTRY_CODE [TABLE_ENTRIES] =
        '{3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] code_bit_positions;
        logic [TIME_BITS-1:0]     on_time;
        logic [TIME_BITS-1:0]     pause_time;
        logic [TIME_BITS-1:0]     red_off_time;
        logic [TIME_BITS-1:0]     blue_off_time;
        logic [TIME_BITS-1:0]     round_gap_time;
    } cfg_t;

    typedef struct packed {
        logic red_on;
        logic green_on;
        logic blue_on;
        logic pattern_active;
    } res_t;

    // A zero duration acts as one millisecond
    function automatic logic [TIME_BITS-1:0] dur(input logic [TIME_BITS-1:0] v);
        return (v == '0) ? TIME_BITS'(1) : v;
    endfunction

    // Map a fault mask through the table to a set of codes (bit k-1 for code k)
    function automatic logic [NUM_CODES-1:0] map_mask(
        input logic [CFG_DATA_BITS-1:0] positions,
        input logic [MASK_BITS-1:0]     mask
    );
        logic [NUM_CODES-1:0] set;
        logic [POS_BITS-1:0]  pos;
        set = '0;
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            pos = positions[POS_BITS*k +: POS_BITS];
            if (mask[pos])
            begin
                set[CODE_BITS'(ENTRY_CODE[k] - 3'd1)] = 1'b1;
            end
        end
        return set;
    endfunction

    // Smallest present code above c, zero if none
    function automatic logic [CODE_BITS-1:0] next_code(
        input logic [NUM_CODES-1:0] set,
        input logic [CODE_BITS-1:0] c
    );
        logic [CODE_BITS-1:0] nc;
        nc = '0;
        for (int k = NUM_CODES; k >= 1; k--)
        begin
            if ((CODE_BITS'(k) > c) && set[k-1])
            begin
                nc = CODE_BITS'(k);
            end
        end
        return nc;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fclb_if.sv =====
// Request and result channel interfaces of the fault code LED blinker.
// Depends on fclb_pkg for the field widths.
`default_nettype none

interface fclb_req_if;
    logic                            valid;
    logic                            ready;
    logic                            command;
    logic [fclb_pkg::MASK_BITS-1:0]  fault_mask;

    modport source (output valid, output command, output fault_mask, input ready);
    modport sink   (input valid, input command, input fault_mask, output ready);
endinterface

interface fclb_res_if;
    logic valid;
    logic ready;
    logic red_on;
    logic green_on;
    logic blue_on;
    logic pattern_active;

    modport source (output valid, output red_on, output green_on, output blue_on,
                    output pattern_active, input ready);
    modport sink   (input valid, input red_on, input green_on, input blue_on,
                    input pattern_active, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fault_code_led_blinker.sv =====
// Fault code LED blinker top level: configuration registers, pattern
// sequencer and a two-entry result buffer. Depends on fclb_pkg, fclb_if and
// fclb_sequencer.
//
//   channel   direction  handshake      payload
//   request   in         valid/ready    command, fault_mask
//   result    out        valid/ready    red_on, green_on, blue_on, pattern_active
//   config    in         cfg_we         cfg_index, cfg_data
//
// One request per cycle while request ready is high; each result is registered.
// The sequencer state and the result register update in the same cycle.
// A stalled result parks in a skid entry; request ready drops only when
// both entries hold results. rst_n clears the state, the buffer and the
// configuration to its defaults at once.
`default_nettype none

module fault_code_led_blinker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    fclb_req_if.sink                                 request,
    fclb_res_if.source                               result,
    input  wire logic                                cfg_we,
    input  wire logic [fclb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [fclb_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    fclb_pkg::cfg_t cfg_reg;
    fclb_pkg::res_t res;
    fclb_pkg::res_t out_reg;
    fclb_pkg::res_t skid_reg;
    logic           out_valid_reg;
    logic           skid_valid_reg;
    logic           accept;
    logic           pop;

    assign request.ready = !skid_valid_reg;
    assign accept        = request.valid && request.ready;
    assign pop           = out_valid_reg && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_bit_positions <= '0;
            cfg_reg.on_time            <= fclb_pkg::ON_TIME_RST;
            cfg_reg.pause_time         <= fclb_pkg::PAUSE_TIME_RST;
            cfg_reg.red_off_time       <= fclb_pkg::RED_OFF_TIME_RST;
            cfg_reg.blue_off_time      <= fclb_pkg::BLUE_OFF_TIME_RST;
            cfg_reg.round_gap_time     <= fclb_pkg::ROUND_GAP_TIME_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fclb_pkg::CFG_CODE_BIT_POSITIONS:
                    cfg_reg.code_bit_positions <= cfg_data;
                fclb_pkg::CFG_ON_TIME:
                    cfg_reg.on_time <= cfg_data[fclb_pkg::TIME_BITS-1:0];
                fclb_pkg::CFG_PAUSE_TIME:
                    cfg_reg.pause_time <= cfg_data[fclb_pkg::TIME_BITS-1:0];
                fclb_pkg::CFG_RED_OFF_TIME:
                    cfg_reg.red_off_time <= cfg_data[fclb_pkg::TIME_BITS-1:0];
                fclb_pkg::CFG_BLUE_OFF_TIME:
                    cfg_reg.blue_off_time <= cfg_data[fclb_pkg::TIME_BITS-1:0];
                fclb_pkg::CFG_ROUND_GAP_TIME:
                    cfg_reg.round_gap_time <= cfg_data[fclb_pkg::TIME_BITS-1:0];
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    fclb_sequencer u_sequencer (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .command    (request.command),
        .fault_mask (request.fault_mask),
        .cfg        (cfg_reg),
        .res        (res)
    );

    // Result buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result buffer payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.red_on         = out_reg.red_on;
    assign result.green_on       = out_reg.green_on;
    assign result.blue_on        = out_reg.blue_on;
    assign result.pattern_active = out_reg.pattern_active;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output entry is empty");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result.valid)
        else $error("accepted request produced no result");

    a_one_led_in_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
            ($countones({result.red_on, result.green_on, result.blue_on}) <= 1) &&
            (!(result.red_on || result.green_on || result.blue_on) ||
             result.pattern_active))
        else $error("LED lit outside a pattern or more than one LED lit");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/fclb_sequencer.sv =====
// Pattern sequencer: holds the code set and phase state, takes one request
// per cycle and gives the LED view after it. Depends on fclb_pkg.
`default_nettype none

module fclb_sequencer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           step,
    input  wire logic                           command,
    input  wire logic [fclb_pkg::MASK_BITS-1:0] fault_mask,
    input  wire fclb_pkg::cfg_t                 cfg,
    output fclb_pkg::res_t                      res
);

    logic [fclb_pkg::NUM_CODES-1:0]  set_reg,    set_next;
    logic [fclb_pkg::CODE_BITS-1:0]  count_reg,  count_next;
    logic [fclb_pkg::PHASE_BITS-1:0] phase_reg,  phase_next;
    logic [fclb_pkg::CODE_BITS-1:0]  pos_reg,    pos_next;
    logic [fclb_pkg::CODE_BITS-1:0]  code_reg,   code_next;
    logic [fclb_pkg::CODE_BITS-1:0]  blinks_reg, blinks_next;
    logic [fclb_pkg::TIME_BITS-1:0]  timer_reg,  timer_next;

    logic [fclb_pkg::NUM_CODES-1:0]  load_set;
    logic [fclb_pkg::CODE_BITS-1:0]  load_count;
    logic [fclb_pkg::CODE_BITS-1:0]  blinks_dec;
    logic [fclb_pkg::CODE_BITS-1:0]  pos_inc;
    logic [fclb_pkg::CODE_BITS-1:0]  first_code;
    logic [fclb_pkg::CODE_BITS-1:0]  following_code;
    logic [fclb_pkg::TIME_BITS-1:0]  on_dur;
    logic [fclb_pkg::TIME_BITS-1:0]  pause_dur;

    assign load_set       = fclb_pkg::map_mask(cfg.code_bit_positions, fault_mask);
    assign load_count     = fclb_pkg::CODE_BITS'($countones(load_set));
    assign blinks_dec     = blinks_reg - 3'd1;
    assign pos_inc        = pos_reg + 3'd1;
    assign first_code     = fclb_pkg::next_code(set_reg, '0);
    assign following_code = fclb_pkg::next_code(set_reg, code_reg);
    assign on_dur         = fclb_pkg::dur(cfg.on_time);
    assign pause_dur      = fclb_pkg::dur(cfg.pause_time);

    always_comb
    begin
        set_next    = set_reg;
        count_next  = count_reg;
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        code_next   = code_reg;
        blinks_next = blinks_reg;
        timer_next  = timer_reg;
        if (step)
        begin
            if (command == fclb_pkg::CMD_LOAD)
            begin
                // load: restart from the first green blink, or drop to idle
                set_next   = load_set;
                count_next = load_count;
                pos_next   = '0;
                code_next  = '0;
                if (load_count == '0)
                begin
                    phase_next  = fclb_pkg::PH_IDLE;
                    timer_next  = '0;
                    blinks_next = '0;
                end
                else
                begin
                    blinks_next = load_count;
                    phase_next  = fclb_pkg::PH_G_ON;
                    timer_next  = on_dur;
                end
            end
            else if (phase_reg != fclb_pkg::PH_IDLE)
            begin
                if (timer_reg > fclb_pkg::TIME_BITS'(1))
                begin
                    timer_next = timer_reg - fclb_pkg::TIME_BITS'(1);
                end
                else
                begin
                    case (phase_reg)
                        fclb_pkg::PH_G_ON:
                        begin
                            phase_next = fclb_pkg::PH_G_OFF;
                            timer_next = pause_dur;
                        end
                        fclb_pkg::PH_G_OFF:
                        begin
                            blinks_next = blinks_dec;
                            if (blinks_dec != '0)
                            begin
                                phase_next = fclb_pkg::PH_G_ON;
                                timer_next = on_dur;
                            end
                            else
                            begin
                                phase_next = fclb_pkg::PH_PAUSE1;
                                timer_next = pause_dur;
                            end
                        end
                        fclb_pkg::PH_PAUSE1:
                        begin
                            pos_next    = '0;
                            code_next   = first_code;
                            blinks_next = 3'd1;
                            phase_next  = fclb_pkg::PH_R_ON;
                            timer_next  = on_dur;
                        end
                        fclb_pkg::PH_R_ON:
                        begin
                            phase_next = fclb_pkg::PH_R_OFF;
                            timer_next = fclb_pkg::dur(cfg.red_off_time);
                        end
                        fclb_pkg::PH_R_OFF:
                        begin
                            blinks_next = blinks_dec;
                            if (blinks_dec != '0)
                            begin
                                phase_next = fclb_pkg::PH_R_ON;
                                timer_next = on_dur;
                            end
                            else
                            begin
                                phase_next = fclb_pkg::PH_PAUSE2;
                                timer_next = pause_dur;
                            end
                        end
                        fclb_pkg::PH_PAUSE2:
                        begin
                            blinks_next = code_reg;
                            phase_next  = fclb_pkg::PH_B_ON;
                            timer_next  = on_dur;
                        end
                        fclb_pkg::PH_B_ON:
                        begin
                            phase_next = fclb_pkg::PH_B_OFF;
                            timer_next = fclb_pkg::dur(cfg.blue_off_time);
                        end
                        fclb_pkg::PH_B_OFF:
                        begin
                            blinks_next = blinks_dec;
                            if (blinks_dec != '0)
                            begin
                                phase_next = fclb_pkg::PH_B_ON;
                                timer_next = on_dur;
                            end
                            else
                            begin
                                phase_next = fclb_pkg::PH_PAUSE3;
                                timer_next = pause_dur;
                            end
                        end
                        fclb_pkg::PH_PAUSE3:
                        begin
                            // advance to the next code or close the round
                            if (following_code != '0)
                            begin
                                pos_next    = pos_inc;
                                code_next   = following_code;
                                blinks_next = pos_inc + 3'd1;
                                phase_next  = fclb_pkg::PH_R_ON;
                                timer_next  = on_dur;
                            end
                            else
                            begin
                                phase_next = fclb_pkg::PH_GAP;
                                timer_next = fclb_pkg::dur(cfg.round_gap_time);
                            end
                        end
                        fclb_pkg::PH_GAP:
                        begin
                            blinks_next = count_reg;
                            phase_next  = fclb_pkg::PH_G_ON;
                            timer_next  = on_dur;
                        end
                        default:
                        begin
                            phase_next = fclb_pkg::PH_IDLE;
                            timer_next = '0;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_reg    <= '0;
            count_reg  <= '0;
            phase_reg  <= fclb_pkg::PH_IDLE;
            pos_reg    <= '0;
            code_reg   <= '0;
            blinks_reg <= '0;
            timer_reg  <= '0;
        end
        else
        begin
            set_reg    <= set_next;
            count_reg  <= count_next;
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            code_reg   <= code_next;
            blinks_reg <= blinks_next;
            timer_reg  <= timer_next;
        end
    end

    always_comb
    begin
        res.red_on         = (phase_next == fclb_pkg::PH_R_ON);
        res.green_on       = (phase_next == fclb_pkg::PH_G_ON);
        res.blue_on        = (phase_next == fclb_pkg::PH_B_ON);
        res.pattern_active = (phase_next != fclb_pkg::PH_IDLE);
    end

endmodule

`default_nettype wire
